>>> design/wmf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the window minimum filter.
package wmf_pkg;
	localparam int FRAME_REG_W  = 13;
	localparam int WINDOW_REG_W = 7;
	localparam int CFG_INDEX_W  = 4;
	localparam int CFG_DATA_W   = 13;
	localparam int PIXEL_FIELD_W = 32;
	localparam int SUM_FIELD_W   = 63;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 96;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 4'd0,
		REG_FRAME_HEIGHT = 4'd1,
		REG_WINDOW_COLS  = 4'd2,
		REG_WINDOW_ROWS  = 4'd3
	} cfg_reg_t;
endpackage

>>> design/window_min_filter_2d_sum.sv
`timescale 1ns / 1ps
// Top level: 2D sliding window minimum with running sum of the minima.
// A taken pixel word enters ST_BUSY, which loads the result register once the output is free.
// One pixel at a time: none is taken in ST_BUSY (accept, then column memory read-modify-write).
// The column store port does one read and one write per pixel; that sets the rate.
// Reset (arst_n low): registers to 4096/4096/1/1, positions and sum cleared, output empty.
// Column store needs no clearing pass: the first row of every frame ignores its contents.
module window_min_filter_2d_sum #(
	parameter int MAX_WIDTH       = 4096,
	parameter int MAX_HEIGHT      = 4096,
	parameter int MAX_WINDOW_COLS = 64,
	parameter int MAX_WINDOW_ROWS = 64,
	parameter int PIXEL_BITS      = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wmf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wmf_pkg::CFG_DATA_W-1:0]  cfg_data,
	// pixel input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wmf_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] pixel
	// result output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wmf_pkg::OUT_TDATA_W-1:0] m_tdata,   // [31:0] window_min, [94:32] running_sum, [95] 0
	output logic                            m_tlast    // last_of_frame
);
	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 1);
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CSW = (MAX_WINDOW_COLS > 1) ? $clog2(MAX_WINDOW_COLS) : 1;
	localparam int RSW = (MAX_WINDOW_ROWS > 1) ? $clog2(MAX_WINDOW_ROWS) : 1;
	localparam int SUMW = wmf_pkg::SUM_FIELD_W;

	typedef enum logic {ST_IDLE, ST_BUSY} state_t;
	state_t state_q;

	logic [wmf_pkg::FRAME_REG_W-1:0]  frame_width_q, frame_height_q;
	logic [wmf_pkg::WINDOW_REG_W-1:0] window_cols_q, window_rows_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SUMW-1:0] sum_q;

	// per-item flags for the ST_BUSY step
	logic          col_upd_s1, emit_s1, first_row_s1, frame_end_s1;
	logic [AW-1:0] kcol_s1;

	logic [PIXEL_BITS-1:0] out_min_q;
	logic [SUMW-1:0]       out_sum_q;
	logic                  out_valid_q, out_last_q;

	// clamped register values, zero acts as one
	int w_i, h_i, wc_i, wr_i;
	always_comb begin
		w_i  = (frame_width_q == '0) ? 1 :
			((int'(frame_width_q) > MAX_WIDTH) ? MAX_WIDTH : int'(frame_width_q));
		h_i  = (frame_height_q == '0) ? 1 :
			((int'(frame_height_q) > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_height_q));
		wc_i = (window_cols_q == '0) ? 1 :
			((int'(window_cols_q) > MAX_WINDOW_COLS) ? MAX_WINDOW_COLS : int'(window_cols_q));
		wr_i = (window_rows_q == '0) ? 1 :
			((int'(window_rows_q) > MAX_WINDOW_ROWS) ? MAX_WINDOW_ROWS : int'(window_rows_q));
	end

	logic in_acc, cfg_acc, out_free, busy_done;
	logic row_end, frame_end, col_ok, row_ok;
	logic [AW-1:0] kcol;
	logic [PIXEL_BITS-1:0] px, row_min, col_min;
	logic [SUMW-1:0] sum_nx;

	// a pending config write takes the idle slot, pixel waits
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || m_tready;
	assign busy_done = (state_q == ST_BUSY) && out_free;

	assign px        = s_tdata[PIXEL_BITS-1:0];
	assign row_end   = (int'(col_q) + 1 >= w_i);
	assign frame_end = row_end && (int'(row_q) + 1 >= h_i);
	assign col_ok    = (int'(col_q) + 1 >= wc_i);
	assign row_ok    = (int'(row_q) + 1 >= wr_i);
	assign kcol      = AW'(int'(col_q) + 1 - wc_i);
	assign sum_nx    = sum_q + SUMW'(col_min);

	wmf_row_cells #(
		.NCELLS(MAX_WINDOW_COLS), .PB(PIXEL_BITS), .SW(CSW)
	) u_row (
		.clk      (clk),
		.shift    (in_acc),
		.row_start(col_q == '0),
		.px       (px),
		.sel      (CSW'(wc_i - 1)),
		.row_min  (row_min)
	);

	wmf_col_cells #(
		.DEPTH(MAX_WIDTH), .NCELLS(MAX_WINDOW_ROWS), .PB(PIXEL_BITS), .AW(AW), .SW(RSW)
	) u_col (
		.clk      (clk),
		.rd_en    (in_acc && col_ok),
		.rd_addr  (kcol),
		.wr_en    (busy_done && col_upd_s1),
		.wr_addr  (kcol_s1),
		.first_row(first_row_s1),
		.row_min  (row_min),
		.sel      (RSW'(wr_i - 1)),
		.col_min  (col_min)
	);

	// item flags, address and output data (no reset needed)
	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_upd_s1   <= col_ok;
			emit_s1      <= col_ok && row_ok;
			first_row_s1 <= (row_q == '0);
			frame_end_s1 <= frame_end;
			kcol_s1      <= kcol;
		end
		if (busy_done && emit_s1) begin
			out_min_q <= col_min;
			out_sum_q <= sum_nx;
			out_last_q <= frame_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			frame_width_q  <= wmf_pkg::FRAME_REG_W'(4096);
			frame_height_q <= wmf_pkg::FRAME_REG_W'(4096);
			window_cols_q  <= wmf_pkg::WINDOW_REG_W'(1);
			window_rows_q  <= wmf_pkg::WINDOW_REG_W'(1);
			col_q          <= '0;
			row_q          <= '0;
			sum_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			// output register: reload when an item completes, else drop once taken
			if (busy_done) begin
				out_valid_q <= emit_s1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						case (cfg_index)
							wmf_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
							wmf_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
							wmf_pkg::REG_WINDOW_COLS:
								window_cols_q <= cfg_data[wmf_pkg::WINDOW_REG_W-1:0];
							wmf_pkg::REG_WINDOW_ROWS:
								window_rows_q <= cfg_data[wmf_pkg::WINDOW_REG_W-1:0];
							default: ;
						endcase
						// any listed write restarts the frame
						if (cfg_index <= wmf_pkg::REG_WINDOW_ROWS) begin
							col_q <= '0;
							row_q <= '0;
							sum_q <= '0;
						end
					end else if (in_acc) begin
						state_q <= ST_BUSY;
						if (row_end) begin
							col_q <= '0;
							row_q <= frame_end ? '0 : RW'(int'(row_q) + 1);
						end else begin
							col_q <= CW'(int'(col_q) + 1);
						end
					end
				end
				ST_BUSY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (frame_end_s1) begin
							sum_q <= '0;
						end else if (emit_s1) begin
							sum_q <= sum_nx;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_sum_q, wmf_pkg::PIXEL_FIELD_W'(out_min_q)};

	// a held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	// at most one pixel in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_BUSY && !s_tready)
		else $error("second pixel taken while busy");
	// positions wrap to origin after last pixel of a frame
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && frame_end |=> col_q == '0 && row_q == '0)
		else $error("positions failed to wrap");
	// sum restarts after the frame's final item completes
	a_sum_clr: assert property (@(posedge clk) disable iff (!arst_n)
		busy_done && frame_end_s1 |=> sum_q == '0)
		else $error("sum not cleared at frame end");
endmodule

>>> design/wmf_row_cells.sv
`timescale 1ns / 1ps
// Row of cells: cell j holds the minimum of the last j+1 pixels of the current row.
module wmf_row_cells #(
	parameter int NCELLS = 64,
	parameter int PB     = 32,
	parameter int SW     = 6
) (
	input  logic          clk,
	input  logic          shift,
	input  logic          row_start,
	input  logic [PB-1:0] px,
	input  logic [SW-1:0] sel,
	output logic [PB-1:0] row_min
);
	logic [PB-1:0] cell_q [NCELLS];

	always_ff @(posedge clk) begin
		if (shift) begin
			cell_q[0] <= px;
		end
	end

	for (genvar j = 1; j < NCELLS; j++) begin : g_cell
		always_ff @(posedge clk) begin
			if (shift) begin
				// first pixel of a row: older contents belong to the previous row
				if (row_start || px < cell_q[j-1]) begin
					cell_q[j] <= px;
				end else begin
					cell_q[j] <= cell_q[j-1];
				end
			end
		end
	end

	assign row_min = cell_q[sel];
endmodule

>>> design/wmf_col_cells.sv
`timescale 1ns / 1ps
// Column cells: per frame column a stored row of cells over the row minima.
module wmf_col_cells #(
	parameter int DEPTH  = 4096,
	parameter int NCELLS = 64,
	parameter int PB     = 32,
	parameter int AW     = 12,
	parameter int SW     = 6
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          first_row,
	input  logic [PB-1:0] row_min,
	input  logic [SW-1:0] sel,
	output logic [PB-1:0] col_min
);
	logic [NCELLS*PB-1:0] mem [DEPTH];
	logic [NCELLS*PB-1:0] rd_q;
	logic [NCELLS*PB-1:0] chain_nx;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= chain_nx;
		end
	end

	always_comb begin
		chain_nx[PB-1:0] = row_min;
		for (int j = 1; j < NCELLS; j++) begin
			if (first_row || row_min < rd_q[(j-1)*PB +: PB]) begin
				chain_nx[j*PB +: PB] = row_min;
			end else begin
				chain_nx[j*PB +: PB] = rd_q[(j-1)*PB +: PB];
			end
		end
	end

	assign col_min = chain_nx[32'(sel)*PB +: PB];
endmodule
